// ===== rtl/core/bphm_pkg.sv =====
// ----------------------------------------------------------------------------
// bphm_pkg
// Shared types and constants for the board polynomial hash mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package bphm_pkg;

  // Field and state widths
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned RESIDUE_W = 56;
  localparam int unsigned HASH_W    = 64;
  localparam int unsigned HALF_W    = HASH_W / 2;

  // Residue modulus 2^56 - 5; 2^56 folds back as 5
  localparam logic [RESIDUE_W-1:0] HASH_MODULUS = 56'hFF_FFFF_FFFF_FFFB;
  localparam int unsigned          FOLD_FACTOR  = 5;

  // Finalizer multiplier
  localparam logic [HASH_W-1:0] MIX_MULT = 64'd4768777513237032717;

  // Side register value after reset, and the smallest usable side
  localparam logic [CFG_W-1:0] SIDE_RESET = 5'd4;
  localparam logic [CFG_W-1:0] SIDE_MIN   = 5'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;   // fold the accepted cell into the residue
    logic last;   // accepted cell closes the board: capture and clear
    logic pre;    // xorshift steps ahead of the multiply
    logic mul0;   // low x low partial product
    logic mul1;   // high x low partial product, upper half
    logic mul2;   // low x high partial product, upper half
    logic post;   // xorshift steps after the multiply into the output register
  } bphm_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/bphm_datapath.sv =====
// ----------------------------------------------------------------------------
// bphm_datapath
// Residue accumulator with constant-modulus folding, side register, and the
// 64-bit xorshift-multiply finalizer built on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bphm_datapath import bphm_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bphm_cmd_t         cmd,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_side,
  input  wire logic [CELL_W-1:0] cell_value,
  output logic [HASH_W-1:0]      board_hash
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned ACC_W  = RESIDUE_W + SIDE_W + 1;
  localparam int unsigned HI_W   = ACC_W - RESIDUE_W;
  localparam int unsigned FOLD_W = RESIDUE_W + 1;

  logic [CFG_W-1:0]     side_r;
  logic [RESIDUE_W-1:0] residue_r, residue_nxt;
  logic [HASH_W-1:0]    mix_r, mix_nxt;
  logic [HASH_W-1:0]    prod_r, prod_nxt;
  logic [HASH_W-1:0]    hash_r;

  logic [SIDE_W-1:0]    side_eff;
  logic [ACC_W-1:0]     acc;
  logic [HI_W-1:0]      acc_hi;
  logic [FOLD_W-1:0]    fold;
  logic [RESIDUE_W-1:0] reduced;
  logic [HALF_W-1:0]    op_a, op_b;
  logic [HASH_W-1:0]    mul_out;

  function automatic logic [HASH_W-1:0] pre_mix(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] t;
    t = v ^ (v >> 21);
    t = t ^ (t << 37);
    t = t ^ (t >> 4);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] post_mix(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] t;
    t = v ^ (v << 20);
    t = t ^ (t >> 41);
    t = t ^ (t << 5);
    return t;
  endfunction

  // Saturate the configured side into the usable range
  always_comb begin
    if (side_r < SIDE_MIN) begin
      side_eff = SIDE_W'(SIDE_MIN);
    end else if (32'(side_r) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(side_r);
    end
  end

  // Multiply by the radix, add the cell, fold the top bits back by 5, then
  // one conditional subtract brings the value below the modulus
  always_comb begin
    acc     = ACC_W'(residue_r) * ACC_W'(side_eff) + ACC_W'(cell_value);
    acc_hi  = acc[ACC_W-1:RESIDUE_W];
    fold    = FOLD_W'(acc[RESIDUE_W-1:0]) + FOLD_W'(acc_hi) * FOLD_W'(FOLD_FACTOR);
    if (fold >= FOLD_W'(HASH_MODULUS)) begin
      reduced = RESIDUE_W'(fold - FOLD_W'(HASH_MODULUS));
    end else begin
      reduced = fold[RESIDUE_W-1:0];
    end
  end

  // Select operands for the shared multiplier
  always_comb begin
    priority if (cmd.mul1) begin
      op_a = mix_r[HASH_W-1:HALF_W];
      op_b = MIX_MULT[HALF_W-1:0];
    end else if (cmd.mul2) begin
      op_a = mix_r[HALF_W-1:0];
      op_b = MIX_MULT[HASH_W-1:HALF_W];
    end else begin
      op_a = mix_r[HALF_W-1:0];
      op_b = MIX_MULT[HALF_W-1:0];
    end
    mul_out = HASH_W'(op_a) * HASH_W'(op_b);
  end

  // Next values for residue, mix and product registers
  always_comb begin
    residue_nxt = residue_r;
    mix_nxt     = mix_r;
    prod_nxt    = prod_r;
    if (cmd.step) begin
      residue_nxt = cmd.last ? '0 : reduced;
      if (cmd.last) begin
        mix_nxt = HASH_W'(reduced);
      end
    end
    if (cmd.pre) begin
      mix_nxt = pre_mix(mix_r);
    end
    if (cmd.mul0) begin
      prod_nxt = mul_out;
    end else if (cmd.mul1 || cmd.mul2) begin
      prod_nxt = prod_r + {mul_out[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  // Hold side and residue under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_RESET;
      residue_r <= '0;
    end else begin
      if (cfg_we) begin
        side_r <= cfg_side;
      end
      residue_r <= residue_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mix_r  <= mix_nxt;
    prod_r <= prod_nxt;
    if (cmd.post) begin
      hash_r <= post_mix(prod_r);
    end
  end

  assign board_hash = hash_r;

  // Residue stays a proper remainder
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    residue_r < HASH_MODULUS)
    else $error("residue left the modulus range");

  // A closing cell clears the residue
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && cmd.last) |=> residue_r == '0)
    else $error("residue not cleared after final cell");

  // Residue changes only on an accepted cell
  a_residue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.step |=> $stable(residue_r))
    else $error("residue changed without a transaction");

endmodule

`default_nettype wire

// ===== rtl/core/bphm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bphm_ctrl
// Sequencer for the hash mixer: accepts cells, steps the finalizer through
// its multiply phases and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bphm_ctrl import bphm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_final_cell,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output bphm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd.step = 1'b1;
          cmd.last = in_final_cell;
          if (in_final_cell) begin
            state_nxt = S_PRE;
          end
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        // Load the output register once it is free
        if (out_free) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A closing cell starts the finalizer on the next cycle
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_final_cell) |=> state_r == S_PRE)
    else $error("finalizer did not start after final cell");

  // A new result appears only out of the last finalizer phase
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_POST)
    else $error("output valid raised outside the finalizer");

  // Multiply phases follow one another without gaps
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL0 |=> state_r == S_MUL1 ##1 state_r == S_MUL2)
    else $error("multiply phases out of order");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_valid_r || !out_stall))
    else $error("output register loaded while a result waits");

endmodule

`default_nettype wire

// ===== rtl/core/board_polynomial_hash_mixer.sv =====
// ----------------------------------------------------------------------------
// board_polynomial_hash_mixer
// Polynomial board hash with a 64-bit xorshift-multiply finalizer.
// ----------------------------------------------------------------------------
// Cells enter one per transaction in row-major order; each is folded into a
// residue modulo 2^56-5 using the board side (saturated to 2..MAX_SIDE) as
// the radix. A cell without the final flag is taken without a stall, so a
// board streams at one cell per clock. After the flagged cell no cell is
// accepted until the finalizer is done: the cell is folded, S_PRE runs the
// pre-multiply xorshifts, S_MUL0, S_MUL1 and S_MUL2 use the shared 32x32
// multiplier to build the low 64 bits of the product, and S_POST loads the
// output register, waiting if an earlier hash has not yet been taken. The
// output register lets the next board start while a hash is pending. Write
// board_side only while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module board_polynomial_hash_mixer import bphm_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CELL_W-1:0] in_cell_value,
  input  wire logic              in_final_cell,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HASH_W-1:0]      out_board_hash,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_board_side
);

  bphm_cmd_t cmd;
  logic      cfg_we;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bphm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_cell (in_final_cell),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  bphm_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_side   (cfg_board_side),
    .cell_value (in_cell_value),
    .board_hash (out_board_hash)
  );

endmodule

`default_nettype wire
